/* hw/rtl/huffman_code_bit_packer_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman code bit packer
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH

// same-cycle implication
`define HCBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbp assertion failed");

// next-cycle implication
`define HCBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbp assertion failed");

`endif

/* hw/rtl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the Huffman code bit packer modules.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int SYMBOLS_DEF      = 128;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int WORD_BITS        = 32;
    localparam int SYM_FIELD_W      = 7;
    localparam int LEN_FIELD_W      = 6;
    localparam int SYM_CMP_W        = 9;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_LOAD   = 2'd0;
    localparam cmd_t CMD_ENCODE = 2'd1;
    localparam cmd_t CMD_FLUSH  = 2'd2;

    typedef struct packed {
        cmd_t                   cmd;
        logic [SYM_FIELD_W-1:0] symbol;
        logic [WORD_BITS-1:0]   code_word;
        logic [LEN_FIELD_W-1:0] code_length;
    } hcbp_in_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 last;
        logic [WORD_BITS-1:0] bytes_emitted;
    } hcbp_out_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]   code;
        logic [LEN_FIELD_W-1:0] len;
    } hcbp_entry_t;

    typedef struct packed {
        cmd_t        cmd;
        hcbp_entry_t entry;
    } hcbp_req_t;

endpackage

/* hw/rtl/hcbp_code_mem.sv */
// ----------------------------------------------------------------------------
// hcbp_code_mem
// Code table memory: one write port, one registered read port, per-entry
// valid bits so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module hcbp_code_mem #(
    parameter int SYMBOLS = hcbp_pkg::SYMBOLS_DEF,
    localparam int ADDR_W = $clog2(SYMBOLS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  hcbp_pkg::hcbp_entry_t     wr_entry,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output hcbp_pkg::hcbp_entry_t     rd_entry
);
    import hcbp_pkg::*;

    hcbp_entry_t           mem [SYMBOLS];
    hcbp_entry_t           rd_data_reg;
    logic                  rd_vld_reg;
    logic [SYMBOLS-1:0]    vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/hcbp_packer.sv */
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and byte emitter with registered output item and the
// running byte count.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_core_assert.svh"

module hcbp_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  hcbp_pkg::hcbp_req_t   req,
    output logic                  byte_valid,
    input  logic                  byte_ready,
    output hcbp_pkg::hcbp_out_t   byte_item
);
    import hcbp_pkg::*;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int ACC_W     = 7 + LEN_LIMIT;
    localparam int CNT_W     = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]     buf_reg, buf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] byte_cnt_reg, byte_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    hcbp_out_t            out_item_reg, out_item_next;

    logic                 slot_free;
    logic                 emit_ok;
    logic                 flush_emit;
    logic                 out_load;
    logic                 take;
    logic [CNT_W-1:0]     cnt_after;
    logic [ACC_W-1:0]     code_mask;
    logic [ACC_W-1:0]     emit_shift;
    logic [7:0]           flush_byte;

    assign slot_free  = !out_valid_reg || byte_ready;
    assign emit_ok    = (cnt_reg >= CNT_W'(8)) && slot_free;
    assign cnt_after  = emit_ok ? (cnt_reg - CNT_W'(8)) : cnt_reg;
    assign code_mask  = ~({ACC_W{1'b1}} << req.entry.len);
    assign emit_shift = buf_reg >> (cnt_reg - CNT_W'(8));
    assign flush_byte = buf_reg[7:0] << (4'd8 - 4'(cnt_reg));

    always_comb
    begin
        unique case (req.cmd)
            CMD_ENCODE: req_ready = cnt_after < CNT_W'(8);
            CMD_FLUSH:  req_ready = (cnt_reg < CNT_W'(8)) &&
                                    ((cnt_reg == '0) || slot_free);
            default:    req_ready = 1'b1;
        endcase
    end

    assign take       = req_valid && req_ready;
    assign flush_emit = take && (req.cmd == CMD_FLUSH) && (cnt_reg != '0);
    assign out_load   = emit_ok || flush_emit;

    always_comb
    begin
        buf_next       = buf_reg;
        cnt_next       = cnt_after;
        byte_cnt_next  = byte_cnt_reg;
        out_valid_next = out_valid_reg && !byte_ready;
        out_item_next  = out_item_reg;

        if (take && (req.cmd == CMD_ENCODE))
        begin
            buf_next = (buf_reg << req.entry.len) |
                       (ACC_W'(req.entry.code) & code_mask);
            cnt_next = cnt_after + CNT_W'(req.entry.len);
        end
        else if (take && (req.cmd == CMD_FLUSH))
        begin
            buf_next = '0;
            cnt_next = '0;
        end

        if (out_load)
        begin
            out_valid_next              = 1'b1;
            byte_cnt_next               = byte_cnt_reg + 1'b1;
            out_item_next.out_byte      = emit_ok ? emit_shift[7:0] : flush_byte;
            out_item_next.last          = !emit_ok;
            out_item_next.bytes_emitted = byte_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign byte_valid = out_valid_reg;
    assign byte_item  = out_item_reg;

    `HCBP_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_reg <= CNT_W'(ACC_W))
    `HCBP_ASSERT_NOW(a_no_overwrite, out_valid_reg && !byte_ready, !out_load)
    `HCBP_ASSERT_NEXT(a_flush_last, flush_emit, byte_valid && byte_item.last && cnt_reg == '0)
    `HCBP_ASSERT_NEXT(a_count_step, out_load, byte_item.bytes_emitted == byte_cnt_reg)

endmodule

/* hw/rtl/huffman_code_bit_packer_core.sv */
// An item is registered in stage s1 with its code table read before it reaches the packer;
// encoded bits pass the accumulator and the registered output item, and a flush byte is
// loaded into the output item when the packer takes the flush. Table reads are registered.
// Throughput: one item per cycle while each code completes at most one byte and byte_ready
// holds; bytes leave at one per cycle while byte_ready holds, so a code completing more bytes holds the input.
// Reset: asynchronous, clears accumulator, byte count and all table valid bits at once.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Loads code table entries, looks up codes per symbol and packs them into
// bytes, most significant bit first; flush pads any remaining bits into a last byte and marks it.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core #(
    parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_ready,
    input  hcbp_pkg::hcbp_in_t   sym_item,
    output logic                 byte_valid,
    input  logic                 byte_ready,
    output hcbp_pkg::hcbp_out_t  byte_item
);
    import hcbp_pkg::*;

    localparam int ADDR_W    = $clog2(SYMBOLS);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

    logic                   accept;
    logic [SYM_CMP_W-1:0]   sym_ext;
    logic                   in_range;
    logic [ADDR_W-1:0]      addr;
    hcbp_entry_t            wr_entry;
    hcbp_entry_t            rd_entry;
    logic                   wr_en;
    logic                   rd_en;

    logic                   s1_valid_reg, s1_valid_next;
    cmd_t                   s1_cmd_reg, s1_cmd_next;
    logic                   s1_hit_reg, s1_hit_next;

    hcbp_req_t              req;
    logic                   req_ready;

    assign accept   = sym_valid && sym_ready;
    assign sym_ext  = SYM_CMP_W'(sym_item.symbol);
    assign in_range = sym_ext < SYM_CMP_W'(SYMBOLS);
    assign addr     = sym_ext[ADDR_W-1:0];

    assign wr_entry.code = sym_item.code_word;
    assign wr_entry.len  = (sym_item.code_length > LEN_FIELD_W'(LEN_LIMIT)) ?
                           LEN_FIELD_W'(LEN_LIMIT) : sym_item.code_length;

    assign wr_en = accept && in_range && (sym_item.cmd == CMD_LOAD);
    assign rd_en = accept && in_range && (sym_item.cmd == CMD_ENCODE);

    hcbp_code_mem #(
        .SYMBOLS (SYMBOLS)
    ) u_code_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (addr),
        .rd_entry (rd_entry)
    );

    assign sym_ready = !s1_valid_reg || req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !req_ready;
        s1_cmd_next   = s1_cmd_reg;
        s1_hit_next   = s1_hit_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_cmd_next   = sym_item.cmd;
            s1_hit_next   = in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_cmd_reg   <= CMD_LOAD;
            s1_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_cmd_reg   <= s1_cmd_next;
            s1_hit_reg   <= s1_hit_next;
        end
    end

    assign req.cmd   = s1_cmd_reg;
    assign req.entry = s1_hit_reg ? rd_entry : '0;

    hcbp_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s1_valid_reg),
        .req_ready  (req_ready),
        .req        (req),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item)
    );

endmodule
